@@ rtl/core/gstc_pkg.sv @@
// gstc_pkg: shared constants, register indexes and pipeline types of the
// gamepad stick and trigger conditioner
// no dependencies
package gstc_pkg;

  localparam int unsigned MaxExponentDef = 8;
  localparam int unsigned AxisFull       = 32767;
  localparam int unsigned TrigFull       = 255;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 15;

  localparam logic [14:0] LeftDzRst  = 15'd7849;
  localparam logic [14:0] RightDzRst = 15'd8689;
  localparam logic [7:0]  TrigDzRst  = 8'd30;
  localparam logic [3:0]  ExpRst     = 4'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLeftDz   = 3'd0,
    CfgRightDz  = 3'd1,
    CfgTrigDz   = 3'd2,
    CfgStickExp = 3'd3,
    CfgTrigExp  = 3'd4,
    CfgInvert   = 3'd5
  } cfg_idx_e;

  // per-beat side data carried along every stage
  typedef struct packed {
    logic             vld;
    logic             conn;
    logic [15:0]      btn;
    logic [3:0]       neg;
    logic [3:0][14:0] amag;
    logic [1:0][7:0]  trig;
    logic [1:0][15:0] mag;
    logic [3:0]       act;
    logic [3:0]       ovf;
    logic [1:0][7:0]  tout;
  } side_t;

endpackage

@@ rtl/core/gamepad_stick_trigger_conditioner_top.sv @@
// gamepad_stick_trigger_conditioner_top: radial deadzone and power curve
// conditioning of two sticks and two triggers, fully pipelined
// depends on gstc_pkg
//
// usage
//   a report beat is taken on each rising edge with start_i high (busy_o is
//   always low, one beat may enter every cycle). the conditioned report
//   appears on the result ports for one cycle with done_o high, after the
//   beat has passed the chain of stages. the chain includes 16 square-root
//   steps, 16 fraction-divide steps, MAX_EXPONENT - 1 curve multiplies and
//   17 direction-divide steps, each one stage. throughput is one beat a cycle.
//   the receiver cannot stall; results are strobed and must be taken.
//   registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
//   must write them only while no beat is in flight (the block itself does
//   not enforce this). reset clears the valid bits of every stage and loads
//   the register defaults; there is no clearing pass.
module gamepad_stick_trigger_conditioner_top
  import gstc_pkg::*;
#(
  parameter int unsigned MAX_EXPONENT = MaxExponentDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                connected_i,
  input  logic [15:0]         button_bits_i,
  input  logic signed [15:0]  left_x_raw_i,
  input  logic signed [15:0]  left_y_raw_i,
  input  logic signed [15:0]  right_x_raw_i,
  input  logic signed [15:0]  right_y_raw_i,
  input  logic [7:0]          left_trigger_raw_i,
  input  logic [7:0]          right_trigger_raw_i,
  output logic                done_o,
  output logic                connected_out_o,
  output logic [15:0]         buttons_out_o,
  output logic signed [15:0]  left_x_o,
  output logic signed [15:0]  left_y_o,
  output logic signed [15:0]  right_x_o,
  output logic signed [15:0]  right_y_o,
  output logic [7:0]          left_trigger_o,
  output logic [7:0]          right_trigger_o
);

  localparam int unsigned SqrtN  = 16;
  localparam int unsigned DivN   = 16;
  localparam int unsigned PowN   = MAX_EXPONENT - 1;
  localparam int unsigned AdivN  = 17;
  localparam int unsigned EW     = $clog2(MAX_EXPONENT + 1);
  localparam int unsigned SSqrt  = 3;
  localparam int unsigned SPrep  = SSqrt + SqrtN;
  localparam int unsigned SDiv   = SPrep + 1;
  localparam int unsigned SScl   = SDiv + DivN;
  localparam int unsigned SMul   = SScl + PowN + 1;
  localparam int unsigned SAdiv  = SMul + 1;
  localparam int unsigned NSt    = SAdiv + AdivN;

  // configuration registers
  logic [14:0] left_dz_q, right_dz_q;
  logic [7:0]  trig_dz_q;
  logic [3:0]  stick_exp_q, trig_exp_q, invert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_dz_q   <= LeftDzRst;
      right_dz_q  <= RightDzRst;
      trig_dz_q   <= TrigDzRst;
      stick_exp_q <= ExpRst;
      trig_exp_q  <= ExpRst;
      invert_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgLeftDz:   left_dz_q   <= cfg_data_i[14:0];
        CfgRightDz:  right_dz_q  <= cfg_data_i[14:0];
        CfgTrigDz:   trig_dz_q   <= cfg_data_i[7:0];
        CfgStickExp: stick_exp_q <= cfg_data_i[3:0];
        CfgTrigExp:  trig_exp_q  <= cfg_data_i[3:0];
        CfgInvert:   invert_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  function automatic logic [14:0] axis_mag(logic [15:0] raw);
    logic [15:0] n;
    n = ~raw + 16'd1;
    if (raw == 16'h8000) return 15'h7fff;
    else if (raw[15])    return n[14:0];
    else                 return raw[14:0];
  endfunction

  function automatic logic [EW-1:0] eff_exp(logic [3:0] e);
    if (e == 4'd0) return EW'(1);
    else if (32'(e) > MAX_EXPONENT) return EW'(MAX_EXPONENT);
    else return EW'(e);
  endfunction

  assign busy_o = 1'b0;

  // input stage
  side_t in_side;
  always_comb begin
    in_side         = '0;
    in_side.vld     = start_i;
    in_side.conn    = connected_i;
    in_side.btn     = button_bits_i;
    in_side.amag[0] = axis_mag(left_x_raw_i);
    in_side.amag[1] = axis_mag(left_y_raw_i);
    in_side.amag[2] = axis_mag(right_x_raw_i);
    in_side.amag[3] = axis_mag(right_y_raw_i);
    in_side.neg[0]  = left_x_raw_i[15] ^ invert_q[0];
    in_side.neg[1]  = left_y_raw_i[15] ^ invert_q[1];
    in_side.neg[2]  = right_x_raw_i[15] ^ invert_q[2];
    in_side.neg[3]  = right_y_raw_i[15] ^ invert_q[3];
    in_side.trig[0] = left_trigger_raw_i;
    in_side.trig[1] = right_trigger_raw_i;
  end

  side_t side_q [NSt];

  // squares and squared radius
  logic [29:0] sq_q  [4];
  logic [30:0] rad_q [2];
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 4; a++) sq_q[a] <= side_q[0].amag[a] * side_q[0].amag[a];
    for (int s = 0; s < 2; s++) rad_q[s] <= {1'b0, sq_q[2*s]} + {1'b0, sq_q[2*s+1]};
  end

  // integer square root, one result bit a stage
  logic [30:0] rt_rem_q [SqrtN][2];
  logic [30:0] rt_res_q [SqrtN][2];
  for (genvar k = 0; k < SqrtN; k++) begin : g_sqrt
    localparam logic [31:0] B = 32'h1 << (30 - 2*k);
    logic [30:0] rem_d [2];
    logic [30:0] res_d [2];
    always_comb begin
      logic [30:0] rem_i;
      logic [30:0] res_i;
      logic [31:0] trial;
      for (int s = 0; s < 2; s++) begin
        rem_i = (k == 0) ? rad_q[s] : rt_rem_q[(k == 0) ? 0 : k-1][s];
        res_i = (k == 0) ? 31'd0    : rt_res_q[(k == 0) ? 0 : k-1][s];
        trial = {1'b0, res_i} + B;
        if ({1'b0, rem_i} >= trial) begin
          rem_d[s] = 31'({1'b0, rem_i} - trial);
          res_d[s] = 31'({2'b0, res_i[30:1]} + B);
        end else begin
          rem_d[s] = rem_i;
          res_d[s] = {1'b0, res_i[30:1]};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      rt_rem_q[k] <= rem_d;
      rt_res_q[k] <= res_d;
    end
  end

  // deadzone test and fraction set-up; lanes 0/1 sticks, 2/3 triggers
  logic [15:0] den_w  [4];
  logic [15:0] pv     [4];
  logic [15:0] pnum   [4];
  logic [3:0]  pact, povf;
  logic [15:0] num_q  [4];
  always_comb begin
    logic [15:0] dz [4];
    dz[0] = {1'b0, left_dz_q};
    dz[1] = {1'b0, right_dz_q};
    dz[2] = {8'd0, trig_dz_q};
    dz[3] = {8'd0, trig_dz_q};
    pv[0] = rt_res_q[SqrtN-1][0][15:0];
    pv[1] = rt_res_q[SqrtN-1][1][15:0];
    pv[2] = {8'd0, side_q[SPrep-1].trig[0]};
    pv[3] = {8'd0, side_q[SPrep-1].trig[1]};
    for (int l = 0; l < 4; l++) begin
      den_w[l] = ((l < 2) ? 16'(AxisFull) : 16'(TrigFull)) - dz[l];
      pact[l]  = pv[l] > dz[l];
      pnum[l]  = pv[l] - dz[l];
      povf[l]  = pnum[l] >= den_w[l];
    end
  end
  always_ff @(posedge clk_i) num_q <= pnum;

  // fraction divide, one quotient bit a stage
  logic [15:0] dv_rem_q [DivN][4];
  logic [15:0] dv_quo_q [DivN][4];
  for (genvar j = 0; j < DivN; j++) begin : g_div
    logic [15:0] rem_d [4];
    logic [15:0] quo_d [4];
    always_comb begin
      logic [16:0] t;
      logic [15:0] q_i;
      for (int l = 0; l < 4; l++) begin
        t   = {((j == 0) ? num_q[l] : dv_rem_q[(j == 0) ? 0 : j-1][l]), 1'b0};
        q_i = (j == 0) ? 16'd0 : dv_quo_q[(j == 0) ? 0 : j-1][l];
        if (t >= {1'b0, den_w[l]}) begin
          rem_d[l] = 16'(t - {1'b0, den_w[l]});
          quo_d[l] = {q_i[14:0], 1'b1};
        end else begin
          rem_d[l] = t[15:0];
          quo_d[l] = {q_i[14:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      dv_rem_q[j] <= rem_d;
      dv_quo_q[j] <= quo_d;
    end
  end

  // power curve: entry 0 holds the clamped fraction, then one multiply a stage
  logic [16:0] cv_q  [PowN+1][4];
  logic [16:0] scl_q [PowN+1][4];
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      scl_q[0][l] <= side_q[SScl-1].ovf[l] ? 17'h10000 : {1'b0, dv_quo_q[DivN-1][l]};
      cv_q[0][l]  <= side_q[SScl-1].ovf[l] ? 17'h10000 : {1'b0, dv_quo_q[DivN-1][l]};
    end
  end
  for (genvar i = 1; i <= PowN; i++) begin : g_pow
    logic [16:0] cv_d [4];
    always_comb begin
      logic [33:0]   p;
      logic [EW-1:0] e;
      for (int l = 0; l < 4; l++) begin
        e = eff_exp((l < 2) ? stick_exp_q : trig_exp_q);
        p = cv_q[i-1][l] * scl_q[i-1][l];
        cv_d[l] = (EW'(i) < e) ? p[32:16] : cv_q[i-1][l];
      end
    end
    always_ff @(posedge clk_i) begin
      cv_q[i]  <= cv_d;
      scl_q[i] <= scl_q[i-1];
    end
  end

  // lay the curve along the direction, trigger scaling
  logic [31:0] prod_q [4];
  logic [7:0]  mtout  [2];
  always_comb begin
    logic [24:0] tp;
    for (int t = 0; t < 2; t++) begin
      tp       = cv_q[PowN][2+t] * 8'(TrigFull);
      mtout[t] = tp[23:16];
    end
  end
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 4; a++) prod_q[a] <= side_q[SMul-1].amag[a] * cv_q[PowN][a/2];
  end

  // direction divide by twice the magnitude
  logic [16:0] ad_rem_q  [AdivN][4];
  logic [16:0] ad_quo_q  [AdivN][4];
  logic [31:0] ad_prod_q [AdivN][4];
  for (genvar j = 0; j < AdivN; j++) begin : g_adiv
    logic [16:0] rem_d [4];
    logic [16:0] quo_d [4];
    always_comb begin
      logic [31:0] p;
      logic [16:0] r;
      logic [16:0] q_i;
      logic [17:0] t;
      logic [16:0] d2;
      for (int a = 0; a < 4; a++) begin
        p   = (j == 0) ? prod_q[a] : ad_prod_q[(j == 0) ? 0 : j-1][a];
        r   = (j == 0) ? {2'b0, prod_q[a][31:17]} : ad_rem_q[(j == 0) ? 0 : j-1][a];
        q_i = (j == 0) ? 17'd0 : ad_quo_q[(j == 0) ? 0 : j-1][a];
        d2  = {side_q[SAdiv+j-1].mag[a/2], 1'b0};
        t   = {r, p[16-j]};
        if (t >= {1'b0, d2}) begin
          rem_d[a] = 17'(t - {1'b0, d2});
          quo_d[a] = {q_i[15:0], 1'b1};
        end else begin
          rem_d[a] = t[16:0];
          quo_d[a] = {q_i[15:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      ad_rem_q[j] <= rem_d;
      ad_quo_q[j] <= quo_d;
      for (int a = 0; a < 4; a++) begin
        ad_prod_q[j][a] <= (j == 0) ? prod_q[a] : ad_prod_q[(j == 0) ? 0 : j-1][a];
      end
    end
  end

  // side chain with valid bits
  for (genvar k = 0; k < NSt; k++) begin : g_side
    side_t d;
    if (k == 0) begin : g_in
      assign d = in_side;
    end else if (k == SPrep) begin : g_prep
      always_comb begin
        d        = side_q[k-1];
        d.mag[0] = pv[0];
        d.mag[1] = pv[1];
        d.act    = pact;
        d.ovf    = povf;
      end
    end else if (k == SMul) begin : g_mul
      always_comb begin
        d         = side_q[k-1];
        d.tout[0] = mtout[0];
        d.tout[1] = mtout[1];
      end
    end else begin : g_pass
      assign d = side_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) side_q[k] <= '0;
      else         side_q[k] <= d;
    end
  end

  // result beat
  side_t       lst;
  logic [15:0] ax_d [4];
  assign lst = side_q[NSt-1];
  always_comb begin
    logic [14:0] sat;
    logic [16:0] q;
    for (int a = 0; a < 4; a++) begin
      q   = ad_quo_q[AdivN-1][a];
      sat = (q > 17'(AxisFull)) ? 15'(AxisFull) : q[14:0];
      if (!lst.conn || !lst.act[a/2]) ax_d[a] = '0;
      else if (lst.neg[a])            ax_d[a] = 16'd0 - {1'b0, sat};
      else                            ax_d[a] = {1'b0, sat};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= lst.vld;
  end

  always_ff @(posedge clk_i) begin
    connected_out_o <= lst.conn;
    buttons_out_o   <= lst.conn ? lst.btn : 16'd0;
    left_x_o        <= ax_d[0];
    left_y_o        <= ax_d[1];
    right_x_o       <= ax_d[2];
    right_y_o       <= ax_d[3];
    left_trigger_o  <= (lst.conn && lst.act[2]) ? lst.tout[0] : 8'd0;
    right_trigger_o <= (lst.conn && lst.act[3]) ? lst.tout[1] : 8'd0;
  end

endmodule
